### rtl/fyp_pkg.sv
// ----------------------------------------------------------------------------
// fyp_pkg
// Shared types and constants for the Fisher-Yates permutation block.
// ----------------------------------------------------------------------------
package fyp_pkg;

	// Field widths fixed by the interface
	localparam int WORD_W = 16;
	localparam int VAL_W  = 7;
	localparam int POS_W  = 6;

	// Default configuration
	localparam int DEF_MAX_SIZE  = 64;
	localparam int DEF_RAND_BITS = 16;
	localparam logic [VAL_W-1:0] SIZE_RST = 7'd64;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_RDX,
		ST_RDI,
		ST_WRX,
		ST_WRI,
		ST_ERD,
		ST_EOUT
	} fyp_state_t;

	// Store control group
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clear;
	} store_ctrl_t;

endpackage

### rtl/fyp_in_if.sv
// ----------------------------------------------------------------------------
// fyp_in_if
// Input channel: one random word per transaction.
// ----------------------------------------------------------------------------
interface fyp_in_if;
	import fyp_pkg::*;

	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] random_word;

	modport source (output valid, output random_word, input ready);
	modport sink   (input valid, input random_word, output ready);
endinterface

### rtl/fyp_out_if.sv
// ----------------------------------------------------------------------------
// fyp_out_if
// Output channel: one permutation entry per transaction.
// ----------------------------------------------------------------------------
interface fyp_out_if;
	import fyp_pkg::*;

	logic             valid;
	logic             ready;
	logic [POS_W-1:0] position;
	logic [VAL_W-1:0] element_value;
	logic             last_entry;

	modport source (output valid, output position, output element_value,
		output last_entry, input ready);
	modport sink   (input valid, input position, input element_value,
		input last_entry, output ready);
endinterface

### rtl/fyp_mod_serial.sv
// ----------------------------------------------------------------------------
// fyp_mod_serial
// Bit-serial restoring remainder: word mod divisor, one word bit per cycle.
// ----------------------------------------------------------------------------
module fyp_mod_serial
	import fyp_pkg::*;
#(
	parameter int MAX_SIZE  = DEF_MAX_SIZE,
	parameter int RAND_BITS = DEF_RAND_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [WORD_W-1:0]           word,
	input  logic [$clog2(MAX_SIZE):0]   divisor,
	output logic                        done,
	output logic [$clog2(MAX_SIZE)-1:0] remainder
);

	localparam int IW = $clog2(MAX_SIZE);
	localparam int RW = IW + 1;
	localparam int W  = (RAND_BITS < WORD_W) ? RAND_BITS : WORD_W;
	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  sh_q;
	logic [RW-1:0] d_q;
	logic [RW-1:0] r_q;
	logic [RW-1:0] trial;

	// Shift the next word bit into the partial remainder
	assign trial = {r_q[IW-1:0], sh_q[W-1]};

	// Control: run W steps after a start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: restoring subtract per bit
	always_ff @(posedge clk) begin
		if (start) begin
			sh_q <= word[W-1:0];
			d_q  <= divisor;
			r_q  <= '0;
		end else if (busy_q) begin
			sh_q <= sh_q << 1;
			r_q  <= (trial >= d_q) ? (trial - d_q) : trial;
		end
	end

	assign done      = done_q;
	assign remainder = r_q[IW-1:0];

endmodule

### rtl/fyp_store.sv
// ----------------------------------------------------------------------------
// fyp_store
// Permutation store: memory with one read port and one write port and
// per-entry valid bits, so that an unwritten entry reads as its identity value.
// ----------------------------------------------------------------------------
module fyp_store
	import fyp_pkg::*;
#(
	parameter int MAX_SIZE = DEF_MAX_SIZE
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  store_ctrl_t                 ctrl,
	input  logic [$clog2(MAX_SIZE)-1:0] rd_addr,
	input  logic [$clog2(MAX_SIZE)-1:0] wr_addr,
	input  logic [VAL_W-1:0]            wr_data,
	output logic [VAL_W-1:0]            rd_data
);

	localparam int AW = $clog2(MAX_SIZE);

	logic [VAL_W-1:0]    mem [MAX_SIZE];
	logic [MAX_SIZE-1:0] vld_q;
	logic [VAL_W-1:0]    rd_q;
	logic                rd_vld_q;
	logic [AW-1:0]       rd_addr_q;

	// Memory write and registered read
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_q      <= mem[rd_addr];
			rd_addr_q <= rd_addr;
		end
	end

	// Valid bits: drop all on restart, set on write, sample with the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				vld_q <= '0;
			end else if (ctrl.wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (ctrl.rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// An unwritten entry holds its identity value
	assign rd_data = rd_vld_q ? rd_q : (VAL_W'(rd_addr_q) + VAL_W'(1));

endmodule

### rtl/fisher_yates_permutation.sv
// ----------------------------------------------------------------------------
// fisher_yates_permutation
// Fisher-Yates shuffle of 1..n with at most one swap per random word.
// ----------------------------------------------------------------------------
// Each accepted random word performs one swap step while i is above 0: the
// word's low min(RAND_BITS,16) bits are reduced modulo i+1 by a bit-serial
// remainder unit (one bit per cycle), then the store is read at x and i and
// written back swapped, one store access at a time. The word that brings i
// to 0 is followed by the emission of all n entries in position order, each
// entry taking a store read and then an output load, which waits while the
// output side stalls; no word is accepted during emission. Writing perm_size
// restarts the shuffle at once; a size of 0 acts as 1 and a size above
// MAX_SIZE acts as MAX_SIZE. The store needs no clearing pass: its valid
// bits all clear together on a restart.
// ----------------------------------------------------------------------------
module fisher_yates_permutation
	import fyp_pkg::*;
#(
	parameter int MAX_SIZE  = DEF_MAX_SIZE,
	parameter int RAND_BITS = DEF_RAND_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [VAL_W-1:0] cfg_wdata,
	fyp_in_if.sink           rand_in,
	fyp_out_if.source        perm_out
);

	localparam int IW = $clog2(MAX_SIZE);

	fyp_state_t    state_q, state_d;
	logic [VAL_W-1:0] size_q;
	logic [IW-1:0] step_q;
	logic [IW-1:0] x_q;
	logic [IW-1:0] k_q;
	logic [VAL_W-1:0] tmp_q;

	logic          out_v_q;
	logic [POS_W-1:0] out_pos_q;
	logic [VAL_W-1:0] out_val_q;
	logic          out_last_q;

	logic          in_acc;
	logic          mod_start;
	logic          mod_done;
	logic [IW-1:0] mod_rem;
	logic          out_free;
	logic          out_load;
	logic          last_k;
	logic          restart;
	logic [VAL_W-1:0] n_cur;
	logic [VAL_W-1:0] n_new;
	logic [VAL_W-1:0] n_rst;

	store_ctrl_t      st_ctrl;
	logic [IW-1:0]    st_rd_addr;
	logic [IW-1:0]    st_wr_addr;
	logic [VAL_W-1:0] st_wr_data;
	logic [VAL_W-1:0] st_rd_data;

	// Clamp a size register value into 1..MAX_SIZE
	function automatic logic [VAL_W-1:0] eff_size(input logic [VAL_W-1:0] sz);
		logic [VAL_W-1:0] n;
		n = sz;
		if (n == '0) begin
			n = VAL_W'(1);
		end
		if (n > VAL_W'(MAX_SIZE)) begin
			n = VAL_W'(MAX_SIZE);
		end
		return n;
	endfunction

	assign n_cur    = eff_size(size_q);
	assign n_new    = eff_size(cfg_wdata);
	assign n_rst    = cfg_we ? n_new : n_cur;
	assign in_acc   = rand_in.valid && rand_in.ready;
	assign out_free = !out_v_q || perm_out.ready;
	assign last_k   = (k_q == IW'(n_cur - VAL_W'(1)));
	assign out_load = (state_q == ST_EOUT) && out_free;
	assign restart  = cfg_we || (out_load && last_k);

	fyp_mod_serial #(
		.MAX_SIZE  (MAX_SIZE),
		.RAND_BITS (RAND_BITS)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.word      (rand_in.random_word),
		.divisor   ({1'b0, step_q} + (IW + 1)'(1)),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	fyp_store #(
		.MAX_SIZE (MAX_SIZE)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (st_ctrl),
		.rd_addr (st_rd_addr),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data),
		.rd_data (st_rd_data)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (step_q != '0) ? ST_MOD : ST_ERD;
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					state_d = ST_RDX;
				end
			end
			ST_RDX:  state_d = ST_RDI;
			ST_RDI:  state_d = ST_WRX;
			ST_WRX:  state_d = ST_WRI;
			ST_WRI:  state_d = (step_q == IW'(1)) ? ST_ERD : ST_IDLE;
			ST_ERD:  state_d = ST_EOUT;
			ST_EOUT: begin
				if (out_free) begin
					state_d = last_k ? ST_IDLE : ST_ERD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (cfg_we) begin
			state_d = ST_IDLE;
		end
	end

	// Outputs of the sequencer
	always_comb begin
		rand_in.ready = 1'b0;
		mod_start     = 1'b0;
		st_ctrl       = '0;
		st_rd_addr    = k_q;
		st_wr_addr    = x_q;
		st_wr_data    = st_rd_data;
		case (state_q)
			ST_IDLE: begin
				rand_in.ready = 1'b1;
				mod_start     = in_acc && (step_q != '0);
			end
			ST_RDX: begin
				st_ctrl.rd_en = 1'b1;
				st_rd_addr    = x_q;
			end
			ST_RDI: begin
				st_ctrl.rd_en = 1'b1;
				st_rd_addr    = step_q;
			end
			ST_WRX: begin
				st_ctrl.wr_en = 1'b1;
				st_wr_addr    = x_q;
				st_wr_data    = st_rd_data;
			end
			ST_WRI: begin
				st_ctrl.wr_en = 1'b1;
				st_wr_addr    = step_q;
				st_wr_data    = tmp_q;
			end
			ST_ERD: begin
				st_ctrl.rd_en = 1'b1;
				st_rd_addr    = k_q;
			end
			default: begin
			end
		endcase
		st_ctrl.clear = restart;
	end

	// Control registers: state, size, step index, emission counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q  <= SIZE_RST;
			step_q  <= IW'(MAX_SIZE - 1);
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			if (restart) begin
				step_q <= IW'(n_rst - VAL_W'(1));
				k_q    <= '0;
			end else begin
				if (state_q == ST_WRI) begin
					step_q <= step_q - 1'b1;
				end
				if (out_load) begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

	// Hold the swap index and the entry read at x
	always_ff @(posedge clk) begin
		if (mod_done) begin
			x_q <= mod_rem;
		end
		if (state_q == ST_RDI) begin
			tmp_q <= st_rd_data;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (perm_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pos_q  <= POS_W'(k_q);
			out_val_q  <= st_rd_data;
			out_last_q <= last_k;
		end
	end

	assign perm_out.valid         = out_v_q;
	assign perm_out.position      = out_pos_q;
	assign perm_out.element_value = out_val_q;
	assign perm_out.last_entry    = out_last_q;

endmodule
